@@ rtl/core/htbd_pkg.sv @@
package htbd_pkg;

  localparam int NSYM            = 10;
  localparam int SYM_W           = 4;
  localparam int MAX_CODE_BITS   = 9;
  localparam int LEN_W           = 4;
  localparam int IDX_W           = $clog2(NSYM);
  localparam int SEQ_W           = $clog2(2 * NSYM - 1);
  localparam int ROUND_W         = $clog2(NSYM - 1);
  localparam int LANE_BITS       = 16;
  localparam int LANES_PER_REG   = 4;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HIGH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN1,
    ST_SCAN2,
    ST_MERGE
  } build_state_e;

  typedef struct packed {
    logic load_slots;
    logic scan_en;
    logic merge_en;
    logic done;
  } build_ctrl_t;

endpackage

@@ rtl/core/huffman_table_build_and_decode.sv @@
// Huffman code builder and bit-serial decoder for ten symbols. The ten weights are
// written through the configuration port; after reset or any write to a weight
// register the code table is rebuilt before the next bit is taken. The build runs
// nine merge rounds, each a scan of the ten node slots for the lightest entry and a
// second scan for the next lightest (ties go to the older entry), one slot per
// cycle through a single shared weight comparator, then a merge step. The idle state
// sees the stale table and a load step fills the slots; in_stall_o is high from then
// until the build is done. Once the table is ready the decoder takes one code bit
// per cycle unless a held result is stalled; every bit is checked against all ten
// code words at once, so a symbol leaves in the cycle after the bit that ends its
// code, through a one-entry output register. A message that ends inside a code
// gives one result with decode_error_o set.
module huffman_table_build_and_decode #(
  parameter int WEIGHT_BITS = htbd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [htbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [htbd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           code_bit_i,
  input  logic                           end_of_message_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [htbd_pkg::SYM_W-1:0]     symbol_o,
  output logic                           decode_error_o,
  output logic                           last_of_message_o
);
  import htbd_pkg::*;

  localparam int SUM_W = WEIGHT_BITS + $clog2(NSYM);

  // configuration and control state
  logic [WEIGHT_BITS-1:0] wt_q [NSYM];
  build_state_e           state_q, state_d;
  logic                   table_ready_q, table_ready_d;
  logic [MAX_CODE_BITS-1:0] pc_q, pc_d;
  logic [LEN_W-1:0]       pl_q, pl_d;
  logic                   out_valid_q, out_valid_d;
  logic [SYM_W-1:0]       symbol_q;
  logic                   error_q;
  logic                   last_q;

  // build datapath
  logic [SUM_W-1:0]   slot_w_q   [NSYM];
  logic [SEQ_W-1:0]   slot_seq_q [NSYM];
  logic [NSYM-1:0]    slot_mem_q [NSYM];
  logic               slot_act_q [NSYM];
  logic [IDX_W-1:0]   idx_q;
  logic [ROUND_W-1:0] round_q;
  logic [SEQ_W-1:0]   seq_next_q;
  logic               b1_found_q, b2_found_q;
  logic [IDX_W-1:0]   b1_idx_q, b2_idx_q;
  logic [SUM_W-1:0]   b1_w_q, b2_w_q;
  logic [SEQ_W-1:0]   b1_seq_q, b2_seq_q;
  logic [NSYM-1:0]    b1_mem_q, b2_mem_q;

  // code table
  logic [MAX_CODE_BITS-1:0] code_words_q   [NSYM];
  logic [LEN_W-1:0]         code_lengths_q [NSYM];

  build_ctrl_t ctrl;
  logic        cfg_hit;
  logic        in_accept;
  logic        scan_last;
  logic        cand_ok, take;
  logic [SUM_W-1:0] ref_w;
  logic [SEQ_W-1:0] ref_seq;
  logic             ref_found;
  logic [SUM_W-1:0] merged_w;

  logic [MAX_CODE_BITS-1:0] pc_shift;
  logic [LEN_W-1:0]         pl_inc;
  logic                     hit;
  logic [SYM_W-1:0]         hit_sym;
  logic                     res_valid;
  logic [SYM_W-1:0]         res_sym;
  logic                     res_err;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WEIGHTS_LOW, CFG_WEIGHTS_MID, CFG_WEIGHTS_HIGH: cfg_hit = 1'b1;
        default:                                            cfg_hit = 1'b0;
      endcase
    end
  end

  assign scan_last = (idx_q == IDX_W'(NSYM - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!table_ready_q) state_d = ST_INIT;
      ST_INIT:  state_d = ST_SCAN1;
      ST_SCAN1: if (scan_last) state_d = ST_SCAN2;
      ST_SCAN2: if (scan_last) state_d = ST_MERGE;
      ST_MERGE: state_d = (round_q == ROUND_W'(NSYM - 2)) ? ST_IDLE : ST_SCAN1;
      default:  state_d = ST_IDLE;
    endcase
    if (cfg_hit) state_d = ST_IDLE;
  end

  // fsm outputs
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:  ctrl = '0;
      ST_INIT:  ctrl.load_slots = 1'b1;
      ST_SCAN1, ST_SCAN2: ctrl.scan_en = 1'b1;
      ST_MERGE: begin
        ctrl.merge_en = 1'b1;
        ctrl.done     = (round_q == ROUND_W'(NSYM - 2));
      end
      default:  ctrl = '0;
    endcase
  end

  // shared comparator: lightest weight first, older entry on ties
  always_comb begin
    if (state_q == ST_SCAN1) begin
      ref_w     = b1_w_q;
      ref_seq   = b1_seq_q;
      ref_found = b1_found_q;
    end else begin
      ref_w     = b2_w_q;
      ref_seq   = b2_seq_q;
      ref_found = b2_found_q;
    end
    cand_ok = slot_act_q[idx_q] && !((state_q == ST_SCAN2) && (idx_q == b1_idx_q));
    take    = cand_ok && (!ref_found ||
              ({slot_w_q[idx_q], slot_seq_q[idx_q]} < {ref_w, ref_seq}));
  end

  assign merged_w = b1_w_q + b2_w_q;

  // decode of one bit against all code words
  always_comb begin
    pc_shift = {pc_q[MAX_CODE_BITS-2:0], code_bit_i};
    pl_inc   = pl_q + LEN_W'(1);
    hit      = 1'b0;
    hit_sym  = '0;
    for (int s = 0; s < NSYM; s++) begin
      if (!hit && code_lengths_q[s] == pl_inc && code_words_q[s] == pc_shift) begin
        hit     = 1'b1;
        hit_sym = SYM_W'(s);
      end
    end
    res_valid = hit || end_of_message_i || (pl_inc >= LEN_W'(MAX_CODE_BITS));
    res_sym   = hit ? hit_sym : '0;
    res_err   = !hit;
  end

  assign in_stall_o = (state_q != ST_IDLE) || !table_ready_q || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    table_ready_d = table_ready_q;
    pc_d          = pc_q;
    pl_d          = pl_q;
    out_valid_d   = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (ctrl.done) table_ready_d = 1'b1;
    if (in_accept) begin
      if (res_valid) begin
        pc_d        = '0;
        pl_d        = '0;
        out_valid_d = 1'b1;
      end else begin
        pc_d = pc_shift;
        pl_d = pl_inc;
      end
    end
    if (cfg_hit) begin
      table_ready_d = 1'b0;
      pc_d          = '0;
      pl_d          = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      table_ready_q <= 1'b0;
      pc_q          <= '0;
      pl_q          <= '0;
      out_valid_q   <= 1'b0;
      for (int s = 0; s < NSYM; s++) begin
        wt_q[s] <= '0;
      end
    end else begin
      state_q       <= state_d;
      table_ready_q <= table_ready_d;
      pc_q          <= pc_d;
      pl_q          <= pl_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WEIGHTS_LOW: begin
            for (int k = 0; k < LANES_PER_REG; k++) begin
              wt_q[k] <= cfg_wdata_i[LANE_BITS*k +: WEIGHT_BITS];
            end
          end
          CFG_WEIGHTS_MID: begin
            for (int k = 0; k < LANES_PER_REG; k++) begin
              wt_q[LANES_PER_REG + k] <= cfg_wdata_i[LANE_BITS*k +: WEIGHT_BITS];
            end
          end
          CFG_WEIGHTS_HIGH: begin
            for (int k = 0; k < NSYM - 2 * LANES_PER_REG; k++) begin
              wt_q[2 * LANES_PER_REG + k] <= cfg_wdata_i[LANE_BITS*k +: WEIGHT_BITS];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      symbol_q <= res_sym;
      error_q  <= res_err;
      last_q   <= end_of_message_i;
    end
  end

  // table build datapath
  always_ff @(posedge clk_i) begin
    if (ctrl.load_slots) begin
      for (int s = 0; s < NSYM; s++) begin
        slot_w_q[s]       <= SUM_W'(wt_q[s]);
        slot_seq_q[s]     <= SEQ_W'(s);
        slot_mem_q[s]     <= NSYM'(1) << s;
        slot_act_q[s]     <= 1'b1;
        code_words_q[s]   <= '0;
        code_lengths_q[s] <= '0;
      end
      idx_q      <= '0;
      round_q    <= '0;
      seq_next_q <= SEQ_W'(NSYM);
      b1_found_q <= 1'b0;
    end
    if (ctrl.scan_en) begin
      if (take) begin
        if (state_q == ST_SCAN1) begin
          b1_found_q <= 1'b1;
          b1_idx_q   <= idx_q;
          b1_w_q     <= slot_w_q[idx_q];
          b1_seq_q   <= slot_seq_q[idx_q];
          b1_mem_q   <= slot_mem_q[idx_q];
        end else begin
          b2_found_q <= 1'b1;
          b2_idx_q   <= idx_q;
          b2_w_q     <= slot_w_q[idx_q];
          b2_seq_q   <= slot_seq_q[idx_q];
          b2_mem_q   <= slot_mem_q[idx_q];
        end
      end
      if (scan_last) begin
        idx_q <= '0;
        if (state_q == ST_SCAN1) b2_found_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
    if (ctrl.merge_en) begin
      slot_w_q[b1_idx_q]   <= merged_w;
      slot_seq_q[b1_idx_q] <= seq_next_q;
      slot_mem_q[b1_idx_q] <= b1_mem_q | b2_mem_q;
      slot_act_q[b2_idx_q] <= 1'b0;
      seq_next_q           <= seq_next_q + SEQ_W'(1);
      round_q              <= round_q + ROUND_W'(1);
      idx_q                <= '0;
      b1_found_q           <= 1'b0;
      for (int s = 0; s < NSYM; s++) begin
        if ((b1_mem_q[s] || b2_mem_q[s]) && code_lengths_q[s] < LEN_W'(MAX_CODE_BITS)) begin
          if (b1_mem_q[s]) code_words_q[s][code_lengths_q[s]] <= 1'b1;
          code_lengths_q[s] <= code_lengths_q[s] + LEN_W'(1);
        end
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign symbol_o          = symbol_q;
  assign decode_error_o    = error_q;
  assign last_of_message_o = last_q;

endmodule

@@ tb/huffman_table_build_and_decode_tb.sv @@
`timescale 1ns / 1ps

module huffman_table_build_and_decode_tb;
  import htbd_pkg::*;

  localparam int WEIGHT_BITS = WEIGHT_BITS_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic code_bit;
    logic end_of_message;
  } code_bit_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             decode_error;
    logic             last_of_message;
  } decoded_t;

  typedef enum int {
    W_RANDOM,
    W_SPARSE,
    W_TINY,
    W_SKEW
  } weight_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  code_bit_i = 1'b0;
  logic                  end_of_message_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SYM_W-1:0]      symbol_o;
  logic                  decode_error_o;
  logic                  last_of_message_o;

  // decoder state as the block should hold it
  logic [63:0]              w_low = '0;
  logic [63:0]              w_mid = '0;
  logic [31:0]              w_high = '0;
  logic [MAX_CODE_BITS-1:0] code_word [NSYM];
  logic [LEN_W-1:0]         code_len [NSYM];
  logic                     table_ready = 1'b0;
  logic [MAX_CODE_BITS-1:0] partial_code = '0;
  logic [LEN_W-1:0]         partial_len = '0;

  code_bit_t bits_to_send [$];
  decoded_t  symbols_due [$];
  decoded_t  want;
  code_bit_t next_bit;
  int        bits_queued = 0;
  int        mismatches = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        hold_left = 0;
  bit        in_taken = 1'b0;
  bit        no_idle = 1'b0;
  bit        hold_arm = 1'b0;
  bit        hold_taken = 1'b0;

  huffman_table_build_and_decode i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .code_bit_i        (code_bit_i),
    .end_of_message_i  (end_of_message_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .symbol_o          (symbol_o),
    .decode_error_o    (decode_error_o),
    .last_of_message_o (last_of_message_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void build_code();
    int unsigned     wt [NSYM];
    logic [NSYM-1:0] grp [NSYM];
    int unsigned     kw;
    logic [NSYM-1:0] kg;
    logic [15:0]     lane;
    int              n;
    int              j;
    for (int s = 0; s < NSYM; s++) begin
      if (s < 4) lane = w_low[16*s +: 16];
      else if (s < 8) lane = w_mid[16*(s-4) +: 16];
      else lane = w_high[16*(s-8) +: 16];
      wt[s] = lane & ((1 << WEIGHT_BITS) - 1);
      grp[s] = '0;
      grp[s][s] = 1'b1;
      code_word[s] = '0;
      code_len[s] = '0;
    end
    n = NSYM;
    while (n > 1) begin
      // stable insertion sort, ties keep list order
      for (int i = 1; i < n; i++) begin
        kw = wt[i];
        kg = grp[i];
        j = i;
        while (j > 0 && wt[j-1] > kw) begin
          wt[j] = wt[j-1];
          grp[j] = grp[j-1];
          j--;
        end
        wt[j] = kw;
        grp[j] = kg;
      end
      // lightest group gets a 1, next lightest a 0
      for (int s = 0; s < NSYM; s++) begin
        if ((grp[0][s] || grp[1][s]) && code_len[s] < MAX_CODE_BITS) begin
          code_word[s][code_len[s]] = grp[0][s];
          code_len[s]++;
        end
      end
      kw = wt[0] + wt[1];
      kg = grp[0] | grp[1];
      for (int i = 2; i < n; i++) begin
        wt[i-2] = wt[i];
        grp[i-2] = grp[i];
      end
      wt[n-2] = kw;
      grp[n-2] = kg;
      n--;
    end
  endfunction

  function automatic void decode_bit(input logic cbit, input logic eom);
    decoded_t res;
    bit       hit;
    if (!table_ready) begin
      build_code();
      table_ready = 1'b1;
    end
    partial_code = {partial_code[MAX_CODE_BITS-2:0], cbit};
    partial_len++;
    hit = 1'b0;
    res = '0;
    for (int s = 0; s < NSYM; s++) begin
      if (!hit && code_len[s] == partial_len && code_word[s] == partial_code) begin
        hit = 1'b1;
        res.symbol = SYM_W'(s);
        res.last_of_message = eom;
      end
    end
    if (!hit && (eom || partial_len >= MAX_CODE_BITS)) begin
      hit = 1'b1;
      res.decode_error = 1'b1;
      res.last_of_message = eom;
    end
    if (hit) begin
      partial_code = '0;
      partial_len = '0;
      symbols_due.insert(symbols_due.size(), res);
    end
  endfunction

  function automatic logic [63:0] weight_lanes(input weight_style_e style);
    logic [63:0] v;
    for (int k = 0; k < 4; k++) begin
      case (style)
        W_RANDOM: v[16*k +: 16] = 16'($urandom);
        W_SPARSE: v[16*k +: 16] = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
        W_TINY:   v[16*k +: 16] = 16'($urandom_range(0, 3));
        default:  v[16*k +: 16] = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 15));
      endcase
    end
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WEIGHTS_LOW:  w_low = data;
      CFG_WEIGHTS_MID:  w_mid = data;
      CFG_WEIGHTS_HIGH: w_high = data[31:0];
      default: return;
    endcase
    table_ready = 1'b0;
    partial_code = '0;
    partial_len = '0;
  endtask

  task automatic set_weights(input logic [63:0] lo, input logic [63:0] mid,
                             input logic [63:0] hi);
    write_reg(CFG_WEIGHTS_LOW, lo);
    write_reg(CFG_WEIGHTS_MID, mid);
    write_reg(CFG_WEIGHTS_HIGH, hi);
  endtask

  // first nbits of a code word, most significant first
  task automatic queue_code(input int s, input int nbits, input bit eom_last);
    code_bit_t item;
    for (int i = 0; i < nbits; i++) begin
      item.code_bit = code_word[s][int'(code_len[s]) - 1 - i];
      item.end_of_message = eom_last && (i == nbits - 1);
      bits_to_send.insert(bits_to_send.size(), item);
      bits_queued++;
    end
  endtask

  task automatic directed_burst();
    int deep;
    int shallow;
    build_code();
    deep = 0;
    shallow = 0;
    for (int s = 1; s < NSYM; s++) begin
      if (code_len[s] > code_len[deep]) deep = s;
      if (code_len[s] < code_len[shallow]) shallow = s;
    end
    queue_code(deep, int'(code_len[deep]), 1'b1);
    queue_code(shallow, int'(code_len[shallow]), 1'b0);
    queue_code(deep, 1, 1'b1);
    queue_code(shallow, int'(code_len[shallow]), 1'b1);
    queue_code(deep, int'(code_len[deep]) - 1, 1'b1);
  endtask

  task automatic queue_traffic(input int count);
    int        target;
    int        kind;
    int        nsym;
    int        s;
    code_bit_t item;
    build_code();
    target = bits_queued + count;
    while (bits_queued < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 9) begin
        // well-formed message, or one cut short inside a code
        nsym = (kind < 7) ? $urandom_range(1, 5) : $urandom_range(0, 3);
        for (int k = 0; k < nsym; k++) begin
          s = $urandom_range(0, NSYM - 1);
          queue_code(s, int'(code_len[s]), kind < 7 && k == nsym - 1);
        end
        if (kind >= 7) begin
          do s = $urandom_range(0, NSYM - 1); while (code_len[s] < 2);
          queue_code(s, $urandom_range(1, int'(code_len[s]) - 1), 1'b1);
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          item.code_bit = 1'($urandom_range(0, 1));
          item.end_of_message = ($urandom_range(0, 5) == 0);
          bits_to_send.insert(bits_to_send.size(), item);
          bits_queued++;
        end
      end
    end
  endtask

  task automatic drain();
    while (bits_to_send.size() != 0 || in_valid_i || symbols_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // bit sender
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (bits_to_send.size() != 0) begin
        next_bit = bits_to_send[0];
        bits_to_send.delete(0);
        code_bit_i <= next_bit.code_bit;
        end_of_message_i <= next_bit.end_of_message;
        in_valid_i <= 1'b1;
        in_gap = no_idle ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // symbol receiver
  always @(negedge clk_i) begin
    if (hold_arm && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_bit(code_bit_i, end_of_message_i);
        in_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        out_gap = no_idle ? 0 : $urandom_range(0, 4);
        if (symbols_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected transaction: symbol %0d error %0b last %0b",
                     symbol_o, decode_error_o, last_of_message_o);
        end else begin
          want = symbols_due[0];
          symbols_due.delete(0);
          if (symbol_o !== want.symbol || decode_error_o !== want.decode_error ||
              last_of_message_o !== want.last_of_message) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected symbol %0d error %0b last %0b, got %0d %0b %0b",
                       want.symbol, want.decode_error, want.last_of_message,
                       symbol_o, decode_error_o, last_of_message_o);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("huffman_table_build_and_decode_tb failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all weights zero out of reset
    directed_burst();
    drain();

    // fibonacci weights give the deepest tree
    set_weights({16'd3, 16'd2, 16'd1, 16'd1}, {16'd21, 16'd13, 16'd8, 16'd5},
                {$urandom, 16'd55, 16'd34});
    directed_burst();
    queue_traffic(60);
    drain();

    // leave a partial code pending across a write to an unused index
    queue_code(0, int'(code_len[0]) - 1, 1'b0);
    drain();
    write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
    queue_traffic(40);
    drain();

    no_idle = 1'b1;
    set_weights('1, '1, '1);
    queue_traffic(80);
    drain();
    no_idle = 1'b0;

    begin
      logic [15:0] eq;
      eq = 16'($urandom);
      set_weights({4{eq}}, {4{eq}}, {$urandom, eq, eq});
    end
    queue_traffic(80);
    while (in_stall_o || !in_valid_i) @(posedge clk_i);
    hold_arm = 1'b1;
    drain();

    for (int p = 0; p < 4; p++) begin
      if (p == 2)
        write_reg(CFG_WEIGHTS_MID, weight_lanes(weight_style_e'(p)));
      else
        set_weights(weight_lanes(weight_style_e'(p)), weight_lanes(weight_style_e'(p)),
                    weight_lanes(weight_style_e'(p)));
      no_idle = (p == 3);
      queue_traffic(70);
      drain();
    end

    if (mismatches == 0) $display("huffman_table_build_and_decode_tb passed");
    else $display("huffman_table_build_and_decode_tb failed");
    $finish;
  end

endmodule
